// ----- hw/rtl/kct_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package kct_pkg;

    // Table geometry.
    localparam int ENTRIES  = 16;
    localparam int TAG_BITS = 16;
    localparam int IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W    = $clog2(ENTRIES + 1);

    // Field widths of the item formats.
    localparam int TAG_W    = 16;
    localparam int COUNT_W  = 31;
    localparam int STATUS_W = 3;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    typedef enum logic [0:0] {
        CMD_ADD    = 1'b0,
        CMD_REMOVE = 1'b1
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_IGNORED     = 3'd0,
        ST_INCREMENTED = 3'd1,
        ST_INSERTED    = 3'd2,
        ST_DECREMENTED = 3'd3,
        ST_REMOVED     = 3'd4,
        ST_NOT_FOUND   = 3'd5,
        ST_FULL        = 3'd6
    } status_t;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_SCAN,
        FSM_UPDATE,
        FSM_RESP
    } fsm_t;

    typedef struct packed {
        cmd_t               cmd;
        logic               tag_valid;
        logic [TAG_W-1:0]   tag;
        logic [COUNT_W-1:0] amount;
    } in_item_t;

    typedef struct packed {
        status_t            status;
        logic [COUNT_W-1:0] new_count;
    } out_item_t;

    // One write into the table.
    typedef struct packed {
        logic                we_tag;
        logic                we_count;
        logic                set_used;
        logic                clr_used;
        logic [IDX_W-1:0]    addr;
        logic [TAG_BITS-1:0] tag;
        logic [COUNT_W-1:0]  count;
    } tbl_wr_t;

    // What the shared unit reports.
    typedef struct packed {
        logic               tag_eq;
        logic               rm_frees;
        logic [COUNT_W-1:0] sat_sum;
        logic [COUNT_W-1:0] diff;
    } alu_res_t;

endpackage

`default_nettype wire

// ----- hw/rtl/kct_table.sv -----
`timescale 1ns / 1ps
`default_nettype none

module kct_table import kct_pkg::*; (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic [IDX_W-1:0]    rd_addr,
    output logic [TAG_BITS-1:0]      rd_tag,
    output logic [COUNT_W-1:0]       rd_count,
    output logic                     rd_used,
    input  wire tbl_wr_t             wr
);

    logic [TAG_BITS-1:0] tag_mem   [ENTRIES];
    logic [COUNT_W-1:0]  count_mem [ENTRIES];
    logic [ENTRIES-1:0]  used_reg;

    always_ff @(posedge aclk) begin
        if (wr.we_tag) begin
            tag_mem[wr.addr] <= wr.tag;
        end
        if (wr.we_count) begin
            count_mem[wr.addr] <= wr.count;
        end
        rd_tag   <= tag_mem[rd_addr];
        rd_count <= count_mem[rd_addr];
    end

    // Occupancy flags clear at reset; tag and count are only trusted when set.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg <= '0;
            rd_used  <= 1'b0;
        end else begin
            if (wr.set_used) begin
                used_reg[wr.addr] <= 1'b1;
            end else if (wr.clr_used) begin
                used_reg[wr.addr] <= 1'b0;
            end
            rd_used <= used_reg[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/kct_alu.sv -----
`timescale 1ns / 1ps
`default_nettype none

module kct_alu import kct_pkg::*; (
    input  wire logic [TAG_BITS-1:0] key,
    input  wire logic [TAG_BITS-1:0] entry_tag,
    input  wire logic [COUNT_W-1:0]  entry_count,
    input  wire logic [COUNT_W-1:0]  amount,
    output alu_res_t                 res
);

    logic [COUNT_W:0] sum;

    always_comb begin
        sum          = {1'b0, entry_count} + {1'b0, amount};
        res.tag_eq   = (key == entry_tag);
        res.sat_sum  = sum[COUNT_W] ? COUNT_MAX : sum[COUNT_W-1:0];
        res.rm_frees = (entry_count <= amount);
        res.diff     = entry_count - amount;
    end

endmodule

`default_nettype wire

// ----- hw/rtl/keyed_counter_table_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Keyed counter table: a table of ENTRIES tag/count pairs that acts as a counted
// multiset. Each input item is an add or a remove of an amount for a tag, and
// every item yields exactly one result item with a status code and the tag's
// count after the update (zero when the tag is absent). An item with tag_valid
// low or a zero amount is answered as ignored and leaves the table alone. Any
// other item scans the table one entry per clock through a single tag
// comparator, with the table read registered, followed by an update step in
// which the shared adder/subtractor computes the new count and writes it back,
// and a response step that moves the result into the output register once that
// register is free. A new item is taken only when the last one has gone to the
// output register. Adds saturate at the largest 31-bit count; a remove that
// would bring the count to zero or below frees the entry. Only the low TAG_BITS
// bits of the tag take part in matching.
module keyed_counter_table_core import kct_pkg::*; (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire in_item_t  s_data,
    output logic           m_valid,
    input  wire logic      m_ready,
    output out_item_t      m_data
);

    // Sequencer state and the item under work.
    fsm_t                state_reg, state_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    cmd_t                cmd_reg, cmd_next;
    logic [TAG_BITS-1:0] key_reg, key_next;
    logic [COUNT_W-1:0]  amt_reg, amt_next;

    // Scan results: first matching entry and first free entry.
    logic                found_reg, found_next;
    logic [IDX_W-1:0]    match_idx_reg, match_idx_next;
    logic [COUNT_W-1:0]  match_count_reg, match_count_next;
    logic                free_ok_reg, free_ok_next;
    logic [IDX_W-1:0]    free_idx_reg, free_idx_next;

    // Finished result waiting for the output register.
    out_item_t           res_reg, res_next;

    // Output register.
    logic                m_valid_reg, m_valid_next;
    out_item_t           m_data_reg, m_data_next;

    logic [IDX_W-1:0]    rd_addr;
    logic [TAG_BITS-1:0] rd_tag;
    logic [COUNT_W-1:0]  rd_count;
    logic                rd_used;
    tbl_wr_t             wr;
    alu_res_t            alu;
    logic [CNT_W-1:0]    prev_cnt;
    logic [IDX_W-1:0]    prev_idx;
    logic                out_free;
    logic                item_ignored;

    kct_table u_table (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_addr  (rd_addr),
        .rd_tag   (rd_tag),
        .rd_count (rd_count),
        .rd_used  (rd_used),
        .wr       (wr)
    );

    // The one comparator and adder: it checks tags during the scan and works
    // out the new count for the matched entry in the update cycle.
    kct_alu u_alu (
        .key         (key_reg),
        .entry_tag   (rd_tag),
        .entry_count (match_count_reg),
        .amount      (amt_reg),
        .res         (alu)
    );

    assign s_ready      = (state_reg == FSM_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_data       = m_data_reg;
    assign out_free     = !m_valid_reg || m_ready;
    assign item_ignored = !s_data.tag_valid || (s_data.amount == '0);

    // The read issued at count c returns in the next cycle, when the counter
    // already shows c + 1, so the entry being compared is the previous one.
    assign prev_cnt = cnt_reg - CNT_W'(1);
    assign prev_idx = prev_cnt[IDX_W-1:0];
    assign rd_addr  = (cnt_reg < CNT_W'(ENTRIES)) ? cnt_reg[IDX_W-1:0] : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= FSM_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        cnt_reg         <= cnt_next;
        cmd_reg         <= cmd_next;
        key_reg         <= key_next;
        amt_reg         <= amt_next;
        found_reg       <= found_next;
        match_idx_reg   <= match_idx_next;
        match_count_reg <= match_count_next;
        free_ok_reg     <= free_ok_next;
        free_idx_reg    <= free_idx_next;
        res_reg         <= res_next;
        m_data_reg      <= m_data_next;
    end

    always_comb begin
        state_next       = state_reg;
        cnt_next         = cnt_reg;
        cmd_next         = cmd_reg;
        key_next         = key_reg;
        amt_next         = amt_reg;
        found_next       = found_reg;
        match_idx_next   = match_idx_reg;
        match_count_next = match_count_reg;
        free_ok_next     = free_ok_reg;
        free_idx_next    = free_idx_reg;
        res_next         = res_reg;
        m_valid_next     = m_valid_reg;
        m_data_next      = m_data_reg;

        wr          = '0;
        wr.addr     = match_idx_reg;
        wr.tag      = key_reg;
        wr.count    = amt_reg;

        // The consumer frees the output register on its own schedule.
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            FSM_IDLE: begin
                if (s_valid) begin
                    cmd_next     = s_data.cmd;
                    key_next     = s_data.tag[TAG_BITS-1:0];
                    amt_next     = s_data.amount;
                    cnt_next     = '0;
                    found_next   = 1'b0;
                    free_ok_next = 1'b0;
                    if (item_ignored) begin
                        res_next.status    = ST_IGNORED;
                        res_next.new_count = '0;
                        state_next         = FSM_RESP;
                    end else begin
                        state_next = FSM_SCAN;
                    end
                end
            end

            FSM_SCAN: begin
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg != '0) begin
                    if (rd_used && alu.tag_eq && !found_reg) begin
                        found_next       = 1'b1;
                        match_idx_next   = prev_idx;
                        match_count_next = rd_count;
                    end
                    if (!rd_used && !free_ok_reg) begin
                        free_ok_next  = 1'b1;
                        free_idx_next = prev_idx;
                    end
                end
                if (cnt_reg == CNT_W'(ENTRIES)) begin
                    cnt_next   = cnt_reg;
                    state_next = FSM_UPDATE;
                end
            end

            FSM_UPDATE: begin
                res_next.new_count = '0;
                state_next         = FSM_RESP;
                if (cmd_reg == CMD_ADD) begin
                    if (found_reg) begin
                        wr.we_count        = 1'b1;
                        wr.count           = alu.sat_sum;
                        res_next.status    = ST_INCREMENTED;
                        res_next.new_count = alu.sat_sum;
                    end else if (free_ok_reg) begin
                        wr.addr            = free_idx_reg;
                        wr.we_tag          = 1'b1;
                        wr.we_count        = 1'b1;
                        wr.set_used        = 1'b1;
                        res_next.status    = ST_INSERTED;
                        res_next.new_count = amt_reg;
                    end else begin
                        res_next.status = ST_FULL;
                    end
                end else begin
                    if (!found_reg) begin
                        res_next.status = ST_NOT_FOUND;
                    end else if (alu.rm_frees) begin
                        wr.clr_used     = 1'b1;
                        res_next.status = ST_REMOVED;
                    end else begin
                        wr.we_count        = 1'b1;
                        wr.count           = alu.diff;
                        res_next.status    = ST_DECREMENTED;
                        res_next.new_count = alu.diff;
                    end
                end
            end

            FSM_RESP: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    state_next   = FSM_IDLE;
                end
            end

            default: begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    // A live item always goes into the scan, starting from the first entry.
    a_live_item_scans: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_data.tag_valid && (s_data.amount != '0))
        |=> (state_reg == FSM_SCAN) && (cnt_reg == '0))
        else $error("live item did not start a scan");

    // The update only happens after every entry has been compared.
    a_scan_complete: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == FSM_UPDATE) |-> (cnt_reg == CNT_W'(ENTRIES)))
        else $error("update before scan finished");

    // An insert claims a free slot only when the tag is absent.
    a_insert_only_new: assert property (@(posedge aclk) disable iff (!aresetn)
        wr.set_used |-> (!found_reg && free_ok_reg && (cmd_reg == CMD_ADD)))
        else $error("insert of a tag that is present or without a free slot");

    // A scanned item never reports itself as ignored.
    a_update_not_ignored: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == FSM_UPDATE) |=> (res_reg.status != ST_IGNORED))
        else $error("scanned item produced an ignored status");

    // The table is written only by the update step.
    a_write_in_update: assert property (@(posedge aclk) disable iff (!aresetn)
        (wr.we_tag || wr.we_count || wr.set_used || wr.clr_used)
        |-> (state_reg == FSM_UPDATE))
        else $error("table write outside the update step");

endmodule

`default_nettype wire
